[rtl/ilte_pkg.sv]
package ilte_pkg;

    localparam int DEPTH      = 64;
    localparam int DATA_WIDTH = 32;
    localparam int ADDR_W     = $clog2(DEPTH);
    localparam int CNT_W      = $clog2(DEPTH + 1);

    localparam int OP_W      = 4;
    localparam int POS_W     = 6;
    localparam int VAL_W     = 32;
    localparam int RD_W      = 32;
    localparam int FPOS_W    = 6;
    localparam int CNT_OUT_W = 7;
    localparam int ERR_W     = 2;

    // common width for position and count compares
    localparam int WIDE_W = CNT_W + POS_W + 1;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH_BACK  = 4'd0,
        OP_POP_BACK   = 4'd1,
        OP_PUSH_FRONT = 4'd2,
        OP_POP_FRONT  = 4'd3,
        OP_SET        = 4'd4,
        OP_GET        = 4'd5,
        OP_REMOVE     = 4'd6,
        OP_FIND       = 4'd7,
        OP_CLEAR      = 4'd8
    } t_opcode;

    typedef enum logic [ERR_W-1:0] {
        ERR_NONE  = 2'd0,
        ERR_RANGE = 2'd1,
        ERR_FULL  = 2'd2
    } t_err;

    typedef enum logic [2:0] {
        ADDR_COUNT,
        ADDR_COUNT_M1,
        ADDR_POS,
        ADDR_IDX,
        ADDR_IDX_M1,
        ADDR_IDX_P1,
        ADDR_ZERO
    } t_addr_sel;

    typedef enum logic {
        WD_VALUE,
        WD_RDATA
    } t_wd_sel;

    typedef enum logic [2:0] {
        IDX_HOLD,
        IDX_LOAD_COUNT,
        IDX_LOAD_POS,
        IDX_ZERO,
        IDX_INC,
        IDX_DEC
    } t_idx_op;

    typedef enum logic [2:0] {
        CNT_HOLD,
        CNT_INC,
        CNT_DEC,
        CNT_CLEAR,
        CNT_ONE
    } t_cnt_op;

    typedef struct packed {
        logic      capture;
        logic      rd_en;
        t_addr_sel rd_addr;
        logic      wr_en;
        t_addr_sel wr_addr;
        t_wd_sel   wr_data;
        t_idx_op   idx_op;
        t_cnt_op   cnt_op;
        logic      err_we;
        t_err      err_code;
        logic      cap_rd;
        logic      set_found;
        logic      load_out;
    } t_dp_cmd;

    typedef struct packed {
        t_opcode opcode;
        logic    empty;
        logic    full;
        logic    pos_oob;
        logic    pos_zero;
        logic    idx_zero;
        logic    sd_more;
        logic    fd_more;
        logic    match;
        logic    out_free;
    } t_dp_status;

endpackage

[rtl/ilte_ram.sv]
module ilte_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/ilte_dp.sv]
module ilte_dp (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic [ilte_pkg::OP_W-1:0]       i_opcode,
    input  logic [ilte_pkg::POS_W-1:0]      i_position,
    input  logic [ilte_pkg::VAL_W-1:0]      i_item_value,
    input  logic                            i_out_stall,
    input  ilte_pkg::t_dp_cmd               i_cmd,
    output ilte_pkg::t_dp_status            o_status,
    output logic                            o_out_valid,
    output logic [ilte_pkg::RD_W-1:0]       o_read_value,
    output logic                            o_found,
    output logic [ilte_pkg::FPOS_W-1:0]     o_found_position,
    output logic [ilte_pkg::CNT_OUT_W-1:0]  o_entry_count,
    output logic [ilte_pkg::ERR_W-1:0]      o_error
);

    import ilte_pkg::*;

    // working registers of the current word
    t_opcode               r_opcode;
    logic [POS_W-1:0]      r_pos;
    logic [DATA_WIDTH-1:0] r_val;
    logic [DATA_WIDTH-1:0] r_rd;
    logic                  r_found;
    logic [CNT_W-1:0]      r_fpos;
    t_err                  r_err;

    logic [CNT_W-1:0]      r_count;
    logic [CNT_W-1:0]      n_count;
    logic [CNT_W-1:0]      r_idx;
    logic [CNT_W-1:0]      n_idx;

    // result register
    logic                  r_out_valid;
    logic [RD_W-1:0]       r_out_rd;
    logic                  r_out_found;
    logic [FPOS_W-1:0]     r_out_fpos;
    logic [CNT_OUT_W-1:0]  r_out_cnt;
    logic [ERR_W-1:0]      r_out_err;

    logic [ADDR_W-1:0]     w_raddr;
    logic [ADDR_W-1:0]     w_waddr;
    logic [DATA_WIDTH-1:0] w_wdata;
    logic [DATA_WIDTH-1:0] w_rdata;

    function automatic logic [ADDR_W-1:0] f_addr(
        input t_addr_sel        sel,
        input logic [CNT_W-1:0] cnt,
        input logic [CNT_W-1:0] idx,
        input logic [POS_W-1:0] pos
    );
        logic [ADDR_W-1:0] a;
        case (sel)
            ADDR_COUNT:    a = ADDR_W'(cnt);
            ADDR_COUNT_M1: a = ADDR_W'(cnt - CNT_W'(1));
            ADDR_POS:      a = ADDR_W'(pos);
            ADDR_IDX:      a = ADDR_W'(idx);
            ADDR_IDX_M1:   a = ADDR_W'(idx - CNT_W'(1));
            ADDR_IDX_P1:   a = ADDR_W'(idx + CNT_W'(1));
            default:       a = '0;
        endcase
        return a;
    endfunction

    always_comb begin
        w_raddr = f_addr(i_cmd.rd_addr, r_count, r_idx, r_pos);
        w_waddr = f_addr(i_cmd.wr_addr, r_count, r_idx, r_pos);
        w_wdata = (i_cmd.wr_data == WD_RDATA) ? w_rdata : r_val;
    end

    ilte_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.wr_en),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (i_cmd.rd_en),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    always_comb begin
        case (i_cmd.cnt_op)
            CNT_INC:   n_count = r_count + CNT_W'(1);
            CNT_DEC:   n_count = r_count - CNT_W'(1);
            CNT_CLEAR: n_count = '0;
            CNT_ONE:   n_count = CNT_W'(1);
            default:   n_count = r_count;
        endcase
        case (i_cmd.idx_op)
            IDX_LOAD_COUNT: n_idx = r_count;
            IDX_LOAD_POS:   n_idx = CNT_W'(r_pos);
            IDX_ZERO:       n_idx = '0;
            IDX_INC:        n_idx = r_idx + CNT_W'(1);
            IDX_DEC:        n_idx = r_idx - CNT_W'(1);
            default:        n_idx = r_idx;
        endcase
    end

    always_comb begin
        o_status.opcode   = r_opcode;
        o_status.empty    = (r_count == '0);
        o_status.full     = (r_count == CNT_W'(DEPTH));
        o_status.pos_oob  = (WIDE_W'(r_pos) >= WIDE_W'(r_count));
        o_status.pos_zero = (r_pos == '0);
        o_status.idx_zero = (r_idx == '0);
        o_status.sd_more  = ((WIDE_W'(r_idx) + WIDE_W'(1)) < WIDE_W'(r_count));
        o_status.fd_more  = (r_idx < r_count);
        o_status.match    = (w_rdata == r_val);
        o_status.out_free = !r_out_valid || !i_out_stall;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx <= n_idx;
        if (i_cmd.capture) begin
            r_opcode <= t_opcode'(i_opcode);
            r_pos    <= i_position;
            r_val    <= DATA_WIDTH'(i_item_value);
            r_rd     <= '0;
            r_found  <= 1'b0;
            r_fpos   <= '0;
            r_err    <= ERR_NONE;
        end else begin
            if (i_cmd.cap_rd) begin
                r_rd <= w_rdata;
            end
            if (i_cmd.set_found) begin
                r_found <= 1'b1;
                r_fpos  <= r_idx;
            end
            if (i_cmd.err_we) begin
                r_err <= i_cmd.err_code;
            end
        end
        if (i_cmd.load_out) begin
            r_out_rd    <= RD_W'(r_rd);
            r_out_found <= r_found;
            r_out_fpos  <= FPOS_W'(r_fpos);
            r_out_cnt   <= CNT_OUT_W'(r_count);
            r_out_err   <= r_err;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_read_value     = r_out_rd;
    assign o_found          = r_out_found;
    assign o_found_position = r_out_fpos;
    assign o_entry_count    = r_out_cnt;
    assign o_error          = r_out_err;

endmodule

[rtl/ilte_ctrl.sv]
module ilte_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  ilte_pkg::t_dp_status i_status,
    output ilte_pkg::t_dp_cmd    o_cmd
);

    import ilte_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_RD_WAIT,
        S_PF_RD,
        S_PF_WR,
        S_SD_RD,
        S_SD_WR,
        S_FD_RD,
        S_FD_CMP,
        S_DONE
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_DECODE;
                end
            end
            S_DECODE: begin
                n_state = S_DONE;
                case (i_status.opcode)
                    OP_PUSH_BACK: begin
                        if (i_status.full) begin
                            o_cmd.err_we   = 1'b1;
                            o_cmd.err_code = ERR_FULL;
                        end else begin
                            o_cmd.wr_en   = 1'b1;
                            o_cmd.wr_addr = ADDR_COUNT;
                            o_cmd.wr_data = WD_VALUE;
                            o_cmd.cnt_op  = CNT_INC;
                        end
                    end
                    OP_POP_BACK: begin
                        if (i_status.empty) begin
                            o_cmd.err_we   = 1'b1;
                            o_cmd.err_code = ERR_RANGE;
                        end else begin
                            o_cmd.rd_en   = 1'b1;
                            o_cmd.rd_addr = ADDR_COUNT_M1;
                            o_cmd.cnt_op  = CNT_DEC;
                            n_state       = S_RD_WAIT;
                        end
                    end
                    OP_PUSH_FRONT: begin
                        if (i_status.full) begin
                            o_cmd.err_we   = 1'b1;
                            o_cmd.err_code = ERR_FULL;
                        end else begin
                            o_cmd.idx_op = IDX_LOAD_COUNT;
                            n_state      = S_PF_RD;
                        end
                    end
                    OP_POP_FRONT: begin
                        if (i_status.empty) begin
                            o_cmd.err_we   = 1'b1;
                            o_cmd.err_code = ERR_RANGE;
                        end else begin
                            o_cmd.rd_en   = 1'b1;
                            o_cmd.rd_addr = ADDR_ZERO;
                            o_cmd.idx_op  = IDX_ZERO;
                            n_state       = S_RD_WAIT;
                        end
                    end
                    OP_SET: begin
                        if (i_status.empty && i_status.pos_zero) begin
                            o_cmd.wr_en   = 1'b1;
                            o_cmd.wr_addr = ADDR_POS;
                            o_cmd.wr_data = WD_VALUE;
                            o_cmd.cnt_op  = CNT_ONE;
                        end else if (i_status.pos_oob) begin
                            o_cmd.err_we   = 1'b1;
                            o_cmd.err_code = ERR_RANGE;
                        end else begin
                            o_cmd.wr_en   = 1'b1;
                            o_cmd.wr_addr = ADDR_POS;
                            o_cmd.wr_data = WD_VALUE;
                        end
                    end
                    OP_GET: begin
                        if (i_status.pos_oob) begin
                            o_cmd.err_we   = 1'b1;
                            o_cmd.err_code = ERR_RANGE;
                        end else begin
                            o_cmd.rd_en   = 1'b1;
                            o_cmd.rd_addr = ADDR_POS;
                            n_state       = S_RD_WAIT;
                        end
                    end
                    OP_REMOVE: begin
                        if (i_status.pos_oob) begin
                            o_cmd.err_we   = 1'b1;
                            o_cmd.err_code = ERR_RANGE;
                        end else begin
                            o_cmd.idx_op = IDX_LOAD_POS;
                            n_state      = S_SD_RD;
                        end
                    end
                    OP_FIND: begin
                        o_cmd.idx_op = IDX_ZERO;
                        n_state      = S_FD_RD;
                    end
                    OP_CLEAR: begin
                        o_cmd.cnt_op = CNT_CLEAR;
                    end
                    default: begin
                        n_state = S_DONE;
                    end
                endcase
            end
            S_RD_WAIT: begin
                o_cmd.cap_rd = 1'b1;
                n_state      = (i_status.opcode == OP_POP_FRONT) ? S_SD_RD : S_DONE;
            end
            // shift up toward the back, last entry first
            S_PF_RD: begin
                if (i_status.idx_zero) begin
                    o_cmd.wr_en   = 1'b1;
                    o_cmd.wr_addr = ADDR_ZERO;
                    o_cmd.wr_data = WD_VALUE;
                    o_cmd.cnt_op  = CNT_INC;
                    n_state       = S_DONE;
                end else begin
                    o_cmd.rd_en   = 1'b1;
                    o_cmd.rd_addr = ADDR_IDX_M1;
                    n_state       = S_PF_WR;
                end
            end
            S_PF_WR: begin
                o_cmd.wr_en   = 1'b1;
                o_cmd.wr_addr = ADDR_IDX;
                o_cmd.wr_data = WD_RDATA;
                o_cmd.idx_op  = IDX_DEC;
                n_state       = S_PF_RD;
            end
            // close the gap at idx
            S_SD_RD: begin
                if (i_status.sd_more) begin
                    o_cmd.rd_en   = 1'b1;
                    o_cmd.rd_addr = ADDR_IDX_P1;
                    n_state       = S_SD_WR;
                end else begin
                    o_cmd.cnt_op = CNT_DEC;
                    n_state      = S_DONE;
                end
            end
            S_SD_WR: begin
                o_cmd.wr_en   = 1'b1;
                o_cmd.wr_addr = ADDR_IDX;
                o_cmd.wr_data = WD_RDATA;
                o_cmd.idx_op  = IDX_INC;
                n_state       = S_SD_RD;
            end
            S_FD_RD: begin
                if (i_status.fd_more) begin
                    o_cmd.rd_en   = 1'b1;
                    o_cmd.rd_addr = ADDR_IDX;
                    n_state       = S_FD_CMP;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_FD_CMP: begin
                if (i_status.match) begin
                    o_cmd.set_found = 1'b1;
                    n_state         = S_DONE;
                end else begin
                    o_cmd.idx_op = IDX_INC;
                    n_state      = S_FD_RD;
                end
            end
            S_DONE: begin
                if (i_status.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall = (r_state != S_IDLE);

endmodule

[rtl/indexed_list_table_engine.sv]
// Push back, set, clear and bad ops finish in decode; get and pop back add a read
// wait; push front, pop front and remove shift entries, and find compares from entry zero
// until a match or the end of the list. One word is in flight: a new word is taken only
// after the last result is loaded into the result register. Each entry moved or compared
// takes a read state, then a write or compare state. Synchronous active-low reset empties
// the list; entry RAM is not cleared and needs no sweep.
module indexed_list_table_engine (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic [ilte_pkg::OP_W-1:0]       i_opcode,
    input  logic [ilte_pkg::POS_W-1:0]      i_position,
    input  logic [ilte_pkg::VAL_W-1:0]      i_item_value,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [ilte_pkg::RD_W-1:0]       o_read_value,
    output logic                            o_found,
    output logic [ilte_pkg::FPOS_W-1:0]     o_found_position,
    output logic [ilte_pkg::CNT_OUT_W-1:0]  o_entry_count,
    output logic [ilte_pkg::ERR_W-1:0]      o_error
);

    import ilte_pkg::*;

    t_dp_cmd    w_cmd;
    t_dp_status w_status;

    ilte_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    ilte_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_opcode         (i_opcode),
        .i_position       (i_position),
        .i_item_value     (i_item_value),
        .i_out_stall      (i_out_stall),
        .i_cmd            (w_cmd),
        .o_status         (w_status),
        .o_out_valid      (o_out_valid),
        .o_read_value     (o_read_value),
        .o_found          (o_found),
        .o_found_position (o_found_position),
        .o_entry_count    (o_entry_count),
        .o_error          (o_error)
    );

endmodule

[rtl/ilte_checker.sv]
module ilte_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_in_valid,
    input logic                            o_in_stall,
    input logic                            o_out_valid,
    input logic                            i_out_stall,
    input logic [ilte_pkg::RD_W-1:0]       o_read_value,
    input logic                            o_found,
    input logic [ilte_pkg::FPOS_W-1:0]     o_found_position,
    input logic [ilte_pkg::CNT_OUT_W-1:0]  o_entry_count,
    input logic [ilte_pkg::ERR_W-1:0]      o_error
);

    import ilte_pkg::*;

    // one word in flight: stall rises right after an accept
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("word accepted while another is in flight");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_read_value)
            && $stable(o_entry_count) && $stable(o_error))
        else $error("stalled result changed");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_entry_count <= CNT_OUT_W'(DEPTH))
        else $error("entry count above depth");

    a_found_in_list: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_found |->
            {1'b0, o_found_position} < o_entry_count && o_error == ERR_NONE)
        else $error("found position outside the list");

    a_err_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_error != ERR_NONE |-> o_read_value == '0 && !o_found)
        else $error("error result carries data");

endmodule

bind indexed_list_table_engine ilte_checker u_ilte_checker (.*);

[test/list_result_checker.sv]
module list_result_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    input  logic                            i_in_stall,
    input  logic [ilte_pkg::OP_W-1:0]       i_opcode,
    input  logic [ilte_pkg::POS_W-1:0]      i_position,
    input  logic [ilte_pkg::VAL_W-1:0]      i_item_value,
    input  logic                            i_out_valid,
    input  logic                            i_out_stall,
    input  logic [ilte_pkg::RD_W-1:0]       i_read_value,
    input  logic                            i_found,
    input  logic [ilte_pkg::FPOS_W-1:0]     i_found_position,
    input  logic [ilte_pkg::CNT_OUT_W-1:0]  i_entry_count,
    input  logic [ilte_pkg::ERR_W-1:0]      i_error,
    output int                              o_fail_count,
    output int                              o_pending,
    output int                              o_list_len
);
    import ilte_pkg::*;

    typedef struct packed {
        logic [RD_W-1:0]      read_value;
        logic                 found;
        logic [FPOS_W-1:0]    found_position;
        logic [CNT_OUT_W-1:0] entry_count;
        logic [ERR_W-1:0]     error;
    } t_list_result;

    t_list_result          pending_results[$];
    logic [DATA_WIDTH-1:0] list_words [DEPTH];
    int                    list_len = 0;
    int                    mismatch_count = 0;

    assign o_fail_count = mismatch_count;

    task automatic check_field(input string field, input logic [RD_W-1:0] want,
                               input logic [RD_W-1:0] got);
        if (want !== got) begin
            mismatch_count++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
        end
    endtask

    task automatic predict_list_op(input logic [OP_W-1:0] code, input logic [POS_W-1:0] pos,
                                   input logic [VAL_W-1:0] val, output t_list_result res);
        int i;
        res = '0;
        case (code)
            OP_PUSH_BACK: begin
                if (list_len >= DEPTH) begin
                    res.error = ERR_FULL;
                end else begin
                    list_words[ADDR_W'(list_len)] = val;
                    list_len++;
                end
            end
            OP_POP_BACK: begin
                if (list_len == 0) begin
                    res.error = ERR_RANGE;
                end else begin
                    res.read_value = list_words[ADDR_W'(list_len - 1)];
                    list_len--;
                end
            end
            OP_PUSH_FRONT: begin
                if (list_len >= DEPTH) begin
                    res.error = ERR_FULL;
                end else begin
                    for (i = list_len; i > 0; i--)
                        list_words[ADDR_W'(i)] = list_words[ADDR_W'(i - 1)];
                    list_words[0] = val;
                    list_len++;
                end
            end
            OP_POP_FRONT: begin
                if (list_len == 0) begin
                    res.error = ERR_RANGE;
                end else begin
                    res.read_value = list_words[0];
                    for (i = 0; i < list_len - 1; i++)
                        list_words[ADDR_W'(i)] = list_words[ADDR_W'(i + 1)];
                    list_len--;
                end
            end
            OP_SET: begin
                if (list_len == 0 && pos == 0) begin
                    list_words[0] = val;
                    list_len = 1;
                end else if (pos >= list_len) begin
                    res.error = ERR_RANGE;
                end else begin
                    list_words[pos] = val;
                end
            end
            OP_GET: begin
                if (pos >= list_len)
                    res.error = ERR_RANGE;
                else
                    res.read_value = list_words[pos];
            end
            OP_REMOVE: begin
                if (pos >= list_len) begin
                    res.error = ERR_RANGE;
                end else begin
                    for (i = pos; i < list_len - 1; i++)
                        list_words[ADDR_W'(i)] = list_words[ADDR_W'(i + 1)];
                    list_len--;
                end
            end
            OP_FIND: begin
                for (i = 0; i < list_len; i++) begin
                    if (!res.found && list_words[ADDR_W'(i)] == val) begin
                        res.found = 1'b1;
                        res.found_position = FPOS_W'(i);
                    end
                end
            end
            OP_CLEAR: list_len = 0;
            default: ;
        endcase
        res.entry_count = CNT_OUT_W'(list_len);
    endtask

    always @(posedge i_clk) begin : watch
        t_list_result want;
        if (!i_rst_n) begin
            list_len = 0;
            pending_results.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (pending_results.size() == 0) begin
                    mismatch_count++;
                    $display("%0t: unexpected word, expected none, actual count %0h error %0h",
                             $time, i_entry_count, i_error);
                end else begin
                    want = pending_results.pop_front();
                    check_field("read_value", want.read_value, i_read_value);
                    check_field("found", RD_W'(want.found), RD_W'(i_found));
                    check_field("found_position", RD_W'(want.found_position),
                                RD_W'(i_found_position));
                    check_field("entry_count", RD_W'(want.entry_count), RD_W'(i_entry_count));
                    check_field("error", RD_W'(want.error), RD_W'(i_error));
                end
            end
            if (i_in_valid && !i_in_stall) begin
                predict_list_op(i_opcode, i_position, i_item_value, want);
                pending_results.push_back(want);
            end
        end
        o_pending = pending_results.size();
        o_list_len = list_len;
    end

endmodule

[test/testbench.sv]
module testbench;
    import ilte_pkg::*;

    localparam int WATCHDOG_CYCLES = 3000;
    localparam int RANDOM_WORDS    = 2000;
    localparam int DRAIN_AT        = 1000;
    localparam int HOLD_AT         = 300;
    localparam int HOLD_CYCLES     = 600;
    localparam int MAX_GAP         = 17;
    localparam int TAIL_CYCLES     = 200;
    localparam int POOL_SIZE       = 8;
    localparam int POOL_W          = $clog2(POOL_SIZE);

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    logic [OP_W-1:0]       opcode = '0;
    logic [POS_W-1:0]      position = '0;
    logic [VAL_W-1:0]      item_value = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b1;
    logic [RD_W-1:0]       read_value;
    logic                  found;
    logic [FPOS_W-1:0]     found_position;
    logic [CNT_OUT_W-1:0]  entry_count;
    logic [ERR_W-1:0]      error;

    int                    fail_count;
    int                    pending;
    int                    list_len;
    int                    received = 0;
    int                    idle_cycles = 0;
    bit                    send_burst = 1'b0;
    bit                    recv_burst = 1'b0;
    logic [VAL_W-1:0]      value_pool [POOL_SIZE];

    always #10 clk = ~clk;

    indexed_list_table_engine DUT (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_in_valid       (in_valid),
        .o_in_stall       (in_stall),
        .i_opcode         (opcode),
        .i_position       (position),
        .i_item_value     (item_value),
        .o_out_valid      (out_valid),
        .i_out_stall      (out_stall),
        .o_read_value     (read_value),
        .o_found          (found),
        .o_found_position (found_position),
        .o_entry_count    (entry_count),
        .o_error          (error)
    );

    list_result_checker u_check (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_in_valid       (in_valid),
        .i_in_stall       (in_stall),
        .i_opcode         (opcode),
        .i_position       (position),
        .i_item_value     (item_value),
        .i_out_valid      (out_valid),
        .i_out_stall      (out_stall),
        .i_read_value     (read_value),
        .i_found          (found),
        .i_found_position (found_position),
        .i_entry_count    (entry_count),
        .i_error          (error),
        .o_fail_count     (fail_count),
        .o_pending        (pending),
        .o_list_len       (list_len)
    );

    task automatic send_word(input logic [OP_W-1:0] code, input logic [POS_W-1:0] pos,
                             input logic [VAL_W-1:0] val);
        int gap;
        gap = send_burst ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        opcode     <= code;
        position   <= pos;
        item_value <= val;
        do @(posedge clk); while (in_stall);
    endtask

    always @(posedge clk) begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_CYCLES) begin
            $display("Simulation FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // result side: random stalls, burst stretches, one long hold-off
    initial begin : result_side
        int gap;
        do @(posedge clk); while (!rst_n);
        forever begin
            if (received % 150 == 0)
                recv_burst = ($urandom_range(0, 3) == 0);
            if (received == HOLD_AT)
                gap = HOLD_CYCLES;
            else
                gap = recv_burst ? 0 : $urandom_range(0, MAX_GAP);
            if (gap > 0) begin
                out_stall <= 1'b1;
                repeat (gap) @(posedge clk);
            end
            out_stall <= 1'b0;
            do @(posedge clk); while (!out_valid);
            received++;
        end
    end

    initial begin : word_side
        int                n;
        int                mix;
        int                roll;
        logic [OP_W-1:0]   code;
        logic [POS_W-1:0]  pos;
        logic [VAL_W-1:0]  val;

        value_pool[0] = '0;
        value_pool[1] = '1;
        for (n = 2; n < POOL_SIZE; n++)
            value_pool[n] = $urandom();

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        send_word(OP_POP_BACK, '0, '0);
        send_word(OP_POP_FRONT, '0, '0);
        send_word(OP_GET, '0, '0);
        send_word(OP_REMOVE, '0, '0);
        send_word(OP_SET, 6'd5, 32'h1111_2222);
        send_word(OP_FIND, '0, '0);
        send_word(OP_PUSH_FRONT, '0, 32'hA5A5_A5A5);
        send_word(OP_SET, '0, '1);
        send_word(OP_CLEAR, '1, '1);
        send_word(OP_SET, '0, '0);
        send_word(OP_PUSH_BACK, '0, 32'h1234_5678);
        send_word(OP_PUSH_FRONT, '1, '1);
        send_word(OP_GET, 6'd2, '0);
        send_word(OP_GET, '1, '0);
        send_word(OP_FIND, '0, 32'h1234_5678);
        send_word(OP_FIND, '0, 32'hDEAD_BEEF);
        send_word(OP_REMOVE, 6'd1, '0);
        send_word(OP_POP_FRONT, '0, '0);
        send_word(OP_POP_BACK, '0, '0);
        send_word('1, '1, '1);
        send_word(OP_SET, '1, 32'h5A5A_5A5A);
        send_word(OP_PUSH_BACK, '0, '0);
        send_word(OP_REMOVE, '1, '0);
        send_word(OP_CLEAR, '0, '0);
        send_word(OP_W'(OP_CLEAR + 1), '0, 32'h8000_0001);

        for (n = 0; n < RANDOM_WORDS; n++) begin
            if (n % 100 == 0) begin
                mix = (n == 0) ? 0 : $urandom_range(0, 3);
                send_burst = ($urandom_range(0, 3) == 0);
            end
            if (n == DRAIN_AT) begin
                in_valid <= 1'b0;
                do @(posedge clk); while (pending != 0);
            end
            roll = $urandom_range(0, 99);
            case (mix)
                0: begin
                    if (roll < 45)
                        code = OP_PUSH_BACK;
                    else if (roll < 80)
                        code = OP_PUSH_FRONT;
                    else
                        code = OP_W'($urandom_range(OP_PUSH_BACK, OP_CLEAR));
                end
                1: begin
                    if (roll < 30)
                        code = OP_POP_BACK;
                    else if (roll < 55)
                        code = OP_POP_FRONT;
                    else if (roll < 75)
                        code = OP_REMOVE;
                    else
                        code = OP_W'($urandom_range(OP_PUSH_BACK, OP_CLEAR));
                end
                2: begin
                    if (roll < 3)
                        code = OP_CLEAR;
                    else
                        code = OP_W'($urandom_range(OP_PUSH_BACK, OP_FIND));
                end
                default: code = OP_W'($urandom_range(0, 2**OP_W - 1));
            endcase
            if (list_len > 0 && $urandom_range(0, 3) != 0)
                pos = POS_W'($urandom_range(0, list_len - 1));
            else
                pos = POS_W'($urandom_range(0, 2**POS_W - 1));
            if ($urandom_range(0, 2) == 0)
                val = $urandom();
            else
                val = value_pool[POOL_W'($urandom_range(0, POOL_SIZE - 1))];
            send_word(code, pos, val);
        end

        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
